/* design/ptfm_pkg.sv */
// ----------------------------------------------------------------------------
// Page table frame manager package
// Shared widths, entry constants and operation codes.
// ----------------------------------------------------------------------------
package ptfm_pkg;

    localparam int PAGE_ENTRIES = 4096;
    localparam int PAGE_W       = $clog2(PAGE_ENTRIES);
    localparam int CNT_W        = 13;
    localparam int ADDR_W       = (PAGE_W + 1 > CNT_W) ? PAGE_W + 1 : CNT_W;
    localparam int IDX_W        = 12;
    localparam int FRAME_W      = 20;
    localparam int FLAGS_W      = 9;
    localparam int ENTRY_W      = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int START_W      = 12;

    localparam logic [ENTRY_W-1:0] OS_BITS     = 32'h0000_0E00;
    localparam logic [ENTRY_W-1:0] BLANK_ENTRY = 32'h0000_0002;
    localparam logic [ENTRY_W-1:0] BUSY_BITS   = 32'h0000_0C00;
    localparam logic [ENTRY_W-1:0] IN_USE      = 32'h0000_0800;
    localparam logic [FLAGS_W-1:0] SHARED_FLAGS = 9'h007;

    localparam logic [CNT_W-1:0]      MAX_PAGES_RST  = 13'd4096;
    localparam logic [START_W-1:0]    START_PAGE_RST = 12'd2816;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE = 1'b1;

    typedef enum logic [1:0] {
        FUNC_MAP   = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_ALLOC = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

endpackage

/* design/ptfm_in_if.sv */
// ----------------------------------------------------------------------------
// Page table frame manager request channel
// Valid/ready channel that carries one operation request per transaction.
// ----------------------------------------------------------------------------
interface ptfm_in_if;
    import ptfm_pkg::*;

    logic               valid;
    logic               ready;
    t_func              func;
    logic [IDX_W-1:0]   page_index;
    logic [FRAME_W-1:0] phys_page;
    logic [CNT_W-1:0]   num_pages;
    logic [FLAGS_W-1:0] flags;

    modport source (output valid, func, page_index, phys_page, num_pages, flags,
                    input ready);
    modport sink (input valid, func, page_index, phys_page, num_pages, flags,
                  output ready);
endinterface

/* design/ptfm_out_if.sv */
// ----------------------------------------------------------------------------
// Page table frame manager response channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface ptfm_out_if;
    import ptfm_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [IDX_W-1:0]   alloc_page;
    logic [ENTRY_W-1:0] entry_value;

    modport source (output valid, found, alloc_page, entry_value, input ready);
    modport sink (input valid, found, alloc_page, entry_value, output ready);
endinterface

/* design/ptfm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/page_table_frame_manager.sv */
// ----------------------------------------------------------------------------
// Page table frame manager
// Table of page entries with map, free, first-fit allocate and read requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole entry memory, one entry per cycle,
// writing the blank entry, so it accepts no request until the sweep is done;
// configuration writes are taken during that time. Requests are handled one at
// a time, and every step goes through the single entry memory, which does one
// read and one write per cycle. Map and free walk one entry per cycle from the
// page index, stopping at the end of the table. An allocation scans one page
// per cycle from the start page and then walks the run that it finds. A
// finished result waits in an output register, and the next request is
// accepted while it waits.
module page_table_frame_manager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ptfm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ptfm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ptfm_in_if.sink                          i_in,
    ptfm_out_if.source                       o_out
);
    import ptfm_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WALK   = 6'b000100,
        S_SEARCH = 6'b001000,
        S_READ   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_max_pages;
    logic [START_W-1:0]   r_start_page;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [CNT_W-1:0]     r_left, n_left;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_run, n_run;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [FRAME_W-1:0]   r_pend_frame, n_pend_frame;
    logic [PAGE_W-1:0]    r_pend_addr, n_pend_addr;
    logic                 r_pend, n_pend;
    logic [FLAGS_W-1:0]   r_flags, n_flags;
    logic                 r_alloc, n_alloc;
    logic                 r_free, n_free;
    logic                 r_idx_ok, n_idx_ok;
    logic                 r_res_found, n_res_found;
    logic [IDX_W-1:0]     r_res_base, n_res_base;
    logic [ENTRY_W-1:0]   r_res_value, n_res_value;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IDX_W-1:0]     r_out_base;
    logic [ENTRY_W-1:0]   r_out_value;

    logic                 ram_we;
    logic [PAGE_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [PAGE_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]    bound;
    logic                 in_take;
    logic                 out_load;
    logic                 walk_issue;
    logic                 search_issue;
    logic                 page_busy;
    logic [ENTRY_W-1:0]   old_os;
    logic [ADDR_W-1:0]    run_base;

    ptfm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAGE_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign bound = (ADDR_W'(r_max_pages) < ADDR_W'(PAGE_ENTRIES)) ?
                   ADDR_W'(r_max_pages) : ADDR_W'(PAGE_ENTRIES);

    assign i_in.ready   = (r_state == S_IDLE);
    assign in_take      = i_in.valid && i_in.ready;
    assign out_load     = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);
    assign walk_issue   = (r_left != '0) && (r_addr < ADDR_W'(PAGE_ENTRIES));
    assign search_issue = (r_addr < bound);
    assign page_busy    = (ram_rdata & BUSY_BITS) != '0;
    assign old_os       = ram_rdata & OS_BITS;
    assign run_base     = ADDR_W'(r_pend_addr) + ADDR_W'(1) - ADDR_W'(r_count);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pend_addr;
        ram_wdata = BLANK_ENTRY;
        ram_raddr = r_addr[PAGE_W-1:0];
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr[PAGE_W-1:0];
        end else if (r_state == S_WALK) begin
            ram_we = r_pend;
            if (r_free) begin
                ram_wdata = old_os | BLANK_ENTRY;
            end else begin
                ram_wdata = old_os | {r_pend_frame, 12'h000}
                          | ENTRY_W'(r_flags) | (r_alloc ? IN_USE : '0);
            end
        end else if (r_state == S_IDLE) begin
            ram_raddr = PAGE_W'(i_in.page_index);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_left       = r_left;
        n_count      = r_count;
        n_run        = r_run;
        n_frame      = r_frame;
        n_pend_frame = r_pend_frame;
        n_pend_addr  = r_pend_addr;
        n_pend       = 1'b0;
        n_flags      = r_flags;
        n_alloc      = r_alloc;
        n_free       = r_free;
        n_idx_ok     = r_idx_ok;
        n_res_found  = r_res_found;
        n_res_base   = r_res_base;
        n_res_value  = r_res_value;
        unique case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(PAGE_ENTRIES - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_res_found = 1'b1;
                    n_res_base  = '0;
                    n_res_value = '0;
                    n_addr      = ADDR_W'(i_in.page_index);
                    n_left      = i_in.num_pages;
                    n_count     = i_in.num_pages;
                    n_frame     = i_in.phys_page;
                    n_flags     = i_in.flags;
                    n_alloc     = 1'b0;
                    n_free      = (i_in.func == FUNC_FREE);
                    n_run       = '0;
                    n_idx_ok    = (ADDR_W'(i_in.page_index) < ADDR_W'(PAGE_ENTRIES));
                    unique case (i_in.func)
                        FUNC_MAP, FUNC_FREE: n_state = S_WALK;
                        FUNC_ALLOC: begin
                            n_addr  = ADDR_W'(r_start_page);
                            n_state = S_SEARCH;
                        end
                        FUNC_READ: n_state = S_READ;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_issue) begin
                    n_pend       = 1'b1;
                    n_pend_addr  = r_addr[PAGE_W-1:0];
                    n_pend_frame = r_frame;
                    n_addr       = r_addr + ADDR_W'(1);
                    n_left       = r_left - CNT_W'(1);
                    n_frame      = r_frame + FRAME_W'(1);
                end else if (!r_pend) begin
                    n_state = S_FINISH;
                end
            end
            S_SEARCH: begin
                if (search_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr[PAGE_W-1:0];
                    n_addr      = r_addr + ADDR_W'(1);
                end
                if (r_pend) begin
                    if (page_busy) begin
                        n_run = '0;
                    end else if (r_count == '0) begin
                        n_res_base = IDX_W'(r_pend_addr);
                        n_pend     = 1'b0;
                        n_state    = S_FINISH;
                    end else if (r_run + CNT_W'(1) == r_count) begin
                        n_res_base = IDX_W'(run_base);
                        n_addr     = run_base;
                        n_left     = r_count;
                        n_frame    = FRAME_W'(run_base);
                        n_flags    = SHARED_FLAGS;
                        n_alloc    = 1'b1;
                        n_free     = 1'b0;
                        n_pend     = 1'b0;
                        n_state    = S_WALK;
                    end else begin
                        n_run = r_run + CNT_W'(1);
                    end
                end else if (!search_issue) begin
                    n_res_found = 1'b0;
                    n_state     = S_FINISH;
                end
            end
            S_READ: begin
                n_res_value = r_idx_ok ? ram_rdata : '0;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_pages  <= MAX_PAGES_RST;
            r_start_page <= START_PAGE_RST;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_PAGES:  r_max_pages  <= i_cfg_data;
                    CFG_START_PAGE: r_start_page <= i_cfg_data[START_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_count      <= n_count;
        r_run        <= n_run;
        r_frame      <= n_frame;
        r_pend_frame <= n_pend_frame;
        r_pend_addr  <= n_pend_addr;
        r_flags      <= n_flags;
        r_alloc      <= n_alloc;
        r_free       <= n_free;
        r_idx_ok     <= n_idx_ok;
        r_res_found  <= n_res_found;
        r_res_base   <= n_res_base;
        r_res_value  <= n_res_value;
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_base  <= r_res_base;
            r_out_value <= r_res_value;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.alloc_page  = r_out_base;
    assign o_out.entry_value = r_out_value;

    // The entry memory is never written while the block waits for a request.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("entry memory written while idle");

    // A walk writes back exactly the entry that it read in the previous cycle.
    a_walk_rmw_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && ram_we) |-> (ram_waddr == $past(ram_raddr)))
        else $error("walk write-back address does not match the read");

    // A pending read only exists while walking or searching.
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_WALK) || (r_state == S_SEARCH)))
        else $error("pending read outside of a walk or search");

    // A failed allocation always reports a zero base page.
    a_not_found_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && !r_res_found) |-> (r_res_base == '0))
        else $error("failed allocation reports a nonzero base page");
endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page table frame manager testbench
// Sends map, free, allocate and read requests under several search windows,
// predicts every result from a shadow copy of the entry table and the two
// registers, and compares each response field by field as it is accepted.
// ----------------------------------------------------------------------------
module testbench;
    import ptfm_pkg::*;

    localparam int RANDOM_ITEMS  = 1050;
    localparam int STALL_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 20;

    typedef struct {
        t_func              func;
        logic [IDX_W-1:0]   page_index;
        logic [FRAME_W-1:0] phys_page;
        logic [CNT_W-1:0]   num_pages;
        logic [FLAGS_W-1:0] flags;
    } t_page_request;

    typedef struct {
        logic               found;
        logic [IDX_W-1:0]   alloc_page;
        logic [ENTRY_W-1:0] entry_value;
    } t_page_result;

    typedef enum {RX_STEADY, RX_SPARSE, RX_PERIODIC, RX_COIN} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptfm_in_if  req_if ();
    ptfm_out_if rsp_if ();

    page_table_frame_manager uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_if),
        .o_out      (rsp_if)
    );

    logic [ENTRY_W-1:0] entry_shadow [PAGE_ENTRIES];
    logic [CNT_W-1:0]   max_pages_shadow;
    logic [START_W-1:0] start_page_shadow;
    t_page_result       pending_results [$];

    int  errors;
    int  n_checked;
    int  n_random;
    int  n_reg_writes;
    int  n_alloc_hit;
    int  n_alloc_miss;
    int  func_count [4];
    int  burst_left;
    bit  tx_gaps_on;
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_page_result next_page_result(t_page_request r);
        t_page_result       res;
        int                 k;
        int                 p;
        int                 run;
        int                 bound;
        int                 base_p;
        bit                 hit;
        logic [FRAME_W-1:0] frame;
        res.found       = 1'b1;
        res.alloc_page  = '0;
        res.entry_value = '0;
        case (r.func)
            FUNC_MAP: begin
                for (k = 0; k < r.num_pages; k++) begin
                    p = r.page_index + k;
                    if (p >= PAGE_ENTRIES) break;
                    frame = FRAME_W'(r.phys_page + k);
                    entry_shadow[p] = (entry_shadow[p] & OS_BITS) | {frame, 12'h000}
                                    | ENTRY_W'(r.flags);
                end
            end
            FUNC_FREE: begin
                for (k = 0; k < r.num_pages; k++) begin
                    p = r.page_index + k;
                    if (p >= PAGE_ENTRIES) break;
                    entry_shadow[p] = (entry_shadow[p] & OS_BITS) | BLANK_ENTRY;
                end
            end
            FUNC_ALLOC: begin
                bound  = (max_pages_shadow < PAGE_ENTRIES) ? int'(max_pages_shadow)
                                                           : PAGE_ENTRIES;
                run    = 0;
                hit    = 1'b0;
                base_p = 0;
                for (p = start_page_shadow; p < bound && !hit; p++) begin
                    if ((entry_shadow[p] & BUSY_BITS) != 0) begin
                        run = 0;
                    end else if (r.num_pages == 0) begin
                        hit    = 1'b1;
                        base_p = p;
                    end else begin
                        run++;
                        if (run == r.num_pages) begin
                            hit    = 1'b1;
                            base_p = p + 1 - r.num_pages;
                        end
                    end
                end
                if (hit) begin
                    for (k = 0; k < r.num_pages; k++) begin
                        p     = base_p + k;
                        frame = FRAME_W'(p);
                        entry_shadow[p] = (entry_shadow[p] & OS_BITS) | IN_USE
                                        | {frame, 12'h000} | ENTRY_W'(SHARED_FLAGS);
                    end
                    res.alloc_page = IDX_W'(base_p);
                end else begin
                    res.found = 1'b0;
                end
            end
            FUNC_READ: begin
                res.entry_value = entry_shadow[r.page_index];
            end
        endcase
        return res;
    endfunction

    function automatic t_page_request make_request(t_func f, int idx, int phys, int count,
                                                   int fl);
        t_page_request r;
        r.func       = f;
        r.page_index = IDX_W'(idx);
        r.phys_page  = FRAME_W'(phys);
        r.num_pages  = CNT_W'(count);
        r.flags      = FLAGS_W'(fl);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want,
                     $realtime);
        end
    endtask

    task automatic send_request(input t_page_request r);
        t_page_result res;
        int           gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (tx_gaps_on) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid      <= 1'b1;
        req_if.func       <= r.func;
        req_if.page_index <= r.page_index;
        req_if.phys_page  <= r.phys_page;
        req_if.num_pages  <= r.num_pages;
        req_if.flags      <= r.flags;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        res = next_page_result(r);
        pending_results.push_back(res);
        func_count[int'(r.func)]++;
        if (r.func == FUNC_ALLOC) begin
            if (res.found) n_alloc_hit++;
            else n_alloc_miss++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_MAX_PAGES) max_pages_shadow = CNT_W'(value);
        else start_page_shadow = START_W'(value);
        n_reg_writes++;
    endtask

    task automatic test_after_reset();
        send_request(make_request(FUNC_READ, 0, 0, 0, 0));
        send_request(make_request(FUNC_READ, PAGE_ENTRIES - 1, 0, 0, 0));
        send_request(make_request(FUNC_ALLOC, 0, 0, 0, 0));
        send_request(make_request(FUNC_ALLOC, 0, 0, 3, 0));
        send_request(make_request(FUNC_READ, 2817, 0, 0, 0));
    endtask

    task automatic test_map_and_free();
        send_request(make_request(FUNC_MAP, 4090, 20'hFFFFE, 4096, 9'h1FF));
        send_request(make_request(FUNC_READ, PAGE_ENTRIES - 1, 0, 0, 0));
        send_request(make_request(FUNC_MAP, 2816, 20'hFFFFF, 2, 0));
        send_request(make_request(FUNC_FREE, 2816, 0, 1, 0));
        send_request(make_request(FUNC_READ, 2816, 0, 0, 0));
        send_request(make_request(FUNC_FREE, 4094, 0, 4096, 0));
        send_request(make_request(FUNC_READ, PAGE_ENTRIES - 1, 0, 0, 0));
        send_request(make_request(FUNC_MAP, 0, 20'hAAAAA, 0, 9'h155));
        send_request(make_request(FUNC_FREE, 0, 0, 0, 0));
    endtask

    task automatic test_alloc_bounds();
        drain_results();
        set_register(CFG_MAX_PAGES, 8191);
        set_register(CFG_START_PAGE, 0);
        send_request(make_request(FUNC_ALLOC, 0, 0, 5, 0));
        send_request(make_request(FUNC_ALLOC, 0, 0, 0, 0));
        send_request(make_request(FUNC_ALLOC, 0, 0, 4096, 0));
        drain_results();
        set_register(CFG_MAX_PAGES, 0);
        set_register(CFG_START_PAGE, PAGE_ENTRIES - 1);
        send_request(make_request(FUNC_ALLOC, 0, 0, 1, 0));
        send_request(make_request(FUNC_ALLOC, 0, 0, 0, 0));
        drain_results();
        set_register(CFG_MAX_PAGES, PAGE_ENTRIES);
        send_request(make_request(FUNC_ALLOC, 0, 0, 1, 0));
        send_request(make_request(FUNC_ALLOC, 0, 0, 2, 0));
        send_request(make_request(FUNC_READ, PAGE_ENTRIES - 1, 0, 0, 0));
    endtask

    task automatic test_random_traffic();
        int    window;
        int    first_page;
        int    limit;
        int    phase_len;
        int    pick;
        int    idx;
        int    count;
        t_func f;
        while (n_random < RANDOM_ITEMS) begin
            drain_results();
            first_page = $urandom_range(0, PAGE_ENTRIES - 1);
            window     = $urandom_range(8, 96);
            pick       = $urandom_range(0, 9);
            if (pick < 6) limit = first_page + window;
            else if (pick == 6) limit = $urandom_range(0, first_page);
            else limit = $urandom_range(PAGE_ENTRIES, 8191);
            set_register(CFG_MAX_PAGES, limit);
            set_register(CFG_START_PAGE, first_page);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            phase_len  = $urandom_range(20, 60);
            repeat (phase_len) begin
                pick = $urandom_range(0, 19);
                if (pick < 5) f = FUNC_MAP;
                else if (pick < 9) f = FUNC_FREE;
                else if (pick < 15) f = FUNC_ALLOC;
                else f = FUNC_READ;
                if ($urandom_range(0, 9) == 0) begin
                    idx = $urandom_range(0, PAGE_ENTRIES - 1);
                end else begin
                    idx = (first_page + $urandom_range(0, window + 16) + PAGE_ENTRIES - 8)
                          % PAGE_ENTRIES;
                end
                if ($urandom_range(0, 59) == 0) count = $urandom_range(0, 4096);
                else if (f == FUNC_ALLOC) count = $urandom_range(0, 6);
                else count = $urandom_range(0, 12);
                send_request(make_request(f, idx, $urandom_range(0, 20'hFFFFF), count,
                                          $urandom_range(0, 9'h1FF)));
                n_random++;
            end
        end
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int       left;
        rsp_if.ready = 1'b0;
        mode = RX_STEADY;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(40, 300);
            end
            left--;
            case (mode)
                RX_STEADY:   rsp_if.ready <= 1'b1;
                RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: rsp_if.ready <= ((left % 9) < 3);
                default:     rsp_if.ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_page_result want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", 0, 0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (rsp_if.found !== want.found)
                    report_mismatch("found", 32'(rsp_if.found), 32'(want.found));
                if (rsp_if.alloc_page !== want.alloc_page)
                    report_mismatch("alloc_page", 32'(rsp_if.alloc_page),
                                    32'(want.alloc_page));
                if (rsp_if.entry_value !== want.entry_value)
                    report_mismatch("entry_value", rsp_if.entry_value, want.entry_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_MAP;
        req_if.page_index = '0;
        req_if.phys_page  = '0;
        req_if.num_pages  = '0;
        req_if.flags      = '0;
        errors            = 0;
        n_checked         = 0;
        n_random          = 0;
        n_reg_writes      = 0;
        n_alloc_hit       = 0;
        n_alloc_miss      = 0;
        func_count        = '{default: 0};
        burst_left        = 0;
        tx_gaps_on        = 1'b1;
        idle_cycles       = 0;
        for (int i = 0; i < PAGE_ENTRIES; i++) entry_shadow[i] = BLANK_ENTRY;
        max_pages_shadow  = MAX_PAGES_RST;
        start_page_shadow = START_PAGE_RST;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_map_and_free();
        test_alloc_bounds();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d map, %0d free, %0d allocate and %0d read requests over %0d %s",
                 func_count[FUNC_MAP], func_count[FUNC_FREE], func_count[FUNC_ALLOC],
                 func_count[FUNC_READ], n_reg_writes, "register writes.");
        $display("Checked %0d results; %0d allocations found a run, %0d found none.",
                 n_checked, n_alloc_hit, n_alloc_miss);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
